// ===== hw/rtl/mmc3_bank_and_scanline_irq_defines.svh =====
// ---------------------------------------------------------------------------
// mmc3_bank_and_scanline_irq_defines
// assertion macros for the mapper
// ---------------------------------------------------------------------------
`ifndef MMC3_BANK_AND_SCANLINE_IRQ_DEFINES_SVH
`define MMC3_BANK_AND_SCANLINE_IRQ_DEFINES_SVH
// implication checked on every clock outside reset
`define MMC3_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mmc3 check failed");
// next-cycle implication
`define MMC3_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mmc3 check failed");
`endif

// ===== hw/rtl/mmc3_pkg.sv =====
// ---------------------------------------------------------------------------
// mmc3_pkg
// shared types and constants for the bank mapper
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package mmc3_pkg;
   localparam int VISIBLE_LINES_DEF = 240;
   localparam logic [15:0] ADDR_OUTER   = 16'h5000;
   localparam logic [15:0] DEC_MASK     = 16'hE001;
   localparam logic [15:0] DEC_SELECT   = 16'h8000;
   localparam logic [15:0] DEC_DATA     = 16'h8001;
   localparam logic [15:0] DEC_MIRROR   = 16'hA000;
   localparam logic [15:0] DEC_LATCH    = 16'hC000;
   localparam logic [15:0] DEC_RELOAD   = 16'hC001;
   localparam logic [15:0] DEC_DISABLE  = 16'hE000;
   localparam logic [15:0] DEC_ENABLE   = 16'hE001;
   localparam logic [1:0] CSR_PRG_COUNT = 2'd0;
   localparam logic [1:0] CSR_CHR_COUNT = 2'd1;
   localparam logic [1:0] CSR_FOUR_SCR  = 2'd2;
   localparam logic [1:0] MIRROR_FOUR   = 2'd2;

   // one modulo job: value mod divisor
   typedef struct packed {
      logic        start;
      logic [13:0] value;
      logic [13:0] divisor;
   } mod_cmd_type;

   typedef struct packed {
      logic        done;
      logic [13:0] result;
   } mod_sts_type;
endpackage

// ===== hw/rtl/mmc3_bank_and_scanline_irq.sv =====
// ---------------------------------------------------------------------------
// mmc3_bank_and_scanline_irq
// cartridge bank mapper with scanline interrupt counter
// ---------------------------------------------------------------------------
//  channel  direction  handshake
//  req_     in         req_valid / req_ready
//  rsp_     out        rsp_valid / rsp_ready
//  csr_     in         csr_we, no wait
// ten bank remainders run one after another on one bit-serial remainder unit
// (issue, 14 steps, done); rsp_valid rises once the last result is captured
// the next request is taken the cycle after the response is registered;
// a held response stalls the input
// synchronous active-high reset restores power-on banks, no clearing pass
`timescale 1ns / 1ps
module mmc3_bank_and_scanline_irq
   import mmc3_pkg::*;
#(
   parameter int VISIBLE_LINES = VISIBLE_LINES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [15:0] req_addr,
   input  logic [7:0]  req_data,
   input  logic [8:0]  req_scanline,
   input  logic        req_display_on,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [12:0] rsp_prg_window_0,
   output logic [12:0] rsp_prg_window_1,
   output logic [12:0] rsp_prg_window_2,
   output logic [12:0] rsp_prg_window_3,
   output logic [63:0] rsp_chr_windows,
   output logic [1:0]  rsp_mirror_mode,
   output logic        rsp_irq_out
);
   logic       apply, job_start, capture, mod_done;
   logic [3:0] job;

   mmc3_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .mod_done(mod_done),
      .apply(apply), .job(job), .job_start(job_start), .capture(capture)
   );

   mmc3_datapath #(.VISIBLE_LINES(VISIBLE_LINES)) u_dp (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .apply(apply), .job(job), .job_start(job_start),
      .capture(capture), .req_command(req_command), .req_addr(req_addr),
      .req_data(req_data), .req_scanline(req_scanline),
      .req_display_on(req_display_on), .mod_done(mod_done),
      .rsp_prg_window_0(rsp_prg_window_0), .rsp_prg_window_1(rsp_prg_window_1),
      .rsp_prg_window_2(rsp_prg_window_2), .rsp_prg_window_3(rsp_prg_window_3),
      .rsp_chr_windows(rsp_chr_windows), .rsp_mirror_mode(rsp_mirror_mode),
      .rsp_irq_out(rsp_irq_out)
   );
endmodule

// ===== hw/rtl/mmc3_mod.sv =====
// ---------------------------------------------------------------------------
// mmc3_mod
// restoring remainder unit, one quotient bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module mmc3_mod
   import mmc3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mod_cmd_type cmd,
   output mod_sts_type sts
);
   logic [13:0] rem_ff, rem_in;
   logic [13:0] val_ff, val_in;
   logic [13:0] div_ff, div_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [14:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      val_in  = val_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, val_ff[13]};
      if (cmd.start) begin
         rem_in  = '0;
         val_in  = cmd.value;
         div_in  = cmd.divisor;
         cnt_in  = 4'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = 14'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[13:0];
         end
         val_in = {val_ff[12:0], 1'b0};
         cnt_in = 4'(cnt_ff + 4'd1);
         if (cnt_ff == 4'd13) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      val_ff <= val_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.done   = done_ff;
   assign sts.result = rem_ff;
endmodule

// ===== hw/rtl/mmc3_datapath.sv =====
// ---------------------------------------------------------------------------
// mmc3_datapath
// mapper registers, irq counter and result assembly
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mmc3_bank_and_scanline_irq_defines.svh"
module mmc3_datapath
   import mmc3_pkg::*;
#(
   parameter int VISIBLE_LINES = VISIBLE_LINES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_wdata,
   input  logic        apply,
   input  logic [3:0]  job,
   input  logic        job_start,
   input  logic        capture,
   input  logic        req_command,
   input  logic [15:0] req_addr,
   input  logic [7:0]  req_data,
   input  logic [8:0]  req_scanline,
   input  logic        req_display_on,
   output logic        mod_done,
   output logic [12:0] rsp_prg_window_0,
   output logic [12:0] rsp_prg_window_1,
   output logic [12:0] rsp_prg_window_2,
   output logic [12:0] rsp_prg_window_3,
   output logic [63:0] rsp_chr_windows,
   output logic [1:0]  rsp_mirror_mode,
   output logic        rsp_irq_out
);
   localparam logic [8:0] VIS = 9'(VISIBLE_LINES);

   logic [13:0] prg_count_ff;
   logic [8:0]  chr_count_ff;
   logic        four_ff;
   logic [7:0]  bank_select_ff;
   logic [7:0]  chr_regs_ff [6];
   logic [12:0] prg_regs_ff [2];
   logic [7:0]  outer_ff, reload_val_ff, count_ff;
   logic        mirror_ff, irq_en_ff, pend_ff, pend_vb_ff, irq_ff;
   logic [13:0] n_eff;
   logic [12:0] p_mod_ff [2];
   logic [7:0]  c_mod_ff [8];
   logic [7:0]  raw;
   mod_cmd_type mcmd;
   mod_sts_type msts;
   logic [15:0] dec;
   logic [7:0]  cnt_tmp;
   logic        pend_tmp;
   logic [8:0]  cn;

   assign n_eff = (prg_count_ff < 14'd2) ? 14'd2 :
                  (prg_count_ff > 14'd8192) ? 14'd8192 : prg_count_ff;
   assign cn  = (chr_count_ff > 9'd256) ? 9'd256 : chr_count_ff;
   assign dec = req_addr & DEC_MASK;

   always_comb begin
      case (job[2:0])
         3'd0: raw = chr_regs_ff[0];
         3'd1: raw = 8'(chr_regs_ff[0] + 8'd1);
         3'd2: raw = chr_regs_ff[1];
         3'd3: raw = 8'(chr_regs_ff[1] + 8'd1);
         3'd4: raw = chr_regs_ff[2];
         3'd5: raw = chr_regs_ff[3];
         3'd6: raw = chr_regs_ff[4];
         default: raw = chr_regs_ff[5];
      endcase
      mcmd.start = job_start;
      if (job[3]) begin
         mcmd.value   = {1'b0, prg_regs_ff[job[0]]};
         mcmd.divisor = n_eff;
      end else begin
         mcmd.value   = {6'd0, raw};
         mcmd.divisor = (cn == 9'd0) ? 14'd8 : {5'd0, cn};
      end
   end

   mmc3_mod u_mod (.clock(clock), .reset(reset), .cmd(mcmd), .sts(msts));
   assign mod_done = msts.done;

   // irq counter tick
   always_comb begin
      cnt_tmp  = count_ff;
      pend_tmp = pend_ff;
      if (pend_vb_ff) cnt_tmp = reload_val_ff;
      if (pend_tmp) begin
         cnt_tmp  = reload_val_ff;
         pend_tmp = 1'b0;
      end else if (cnt_tmp != 8'd0) begin
         cnt_tmp = 8'(cnt_tmp - 8'd1);
      end
      if (cnt_tmp == 8'd0) pend_tmp = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (msts.done) begin
         if (job[3]) p_mod_ff[job[0]] <= msts.result[12:0];
         else c_mod_ff[job[2:0]] <= msts.result[7:0];
      end
      if (reset) begin
         prg_count_ff  <= 14'd32;
         chr_count_ff  <= 9'd0;
         four_ff       <= 1'b0;
         bank_select_ff <= 8'd0;
         chr_regs_ff[0] <= 8'd0;
         chr_regs_ff[1] <= 8'd2;
         chr_regs_ff[2] <= 8'd4;
         chr_regs_ff[3] <= 8'd5;
         chr_regs_ff[4] <= 8'd6;
         chr_regs_ff[5] <= 8'd7;
         prg_regs_ff[0] <= 13'd0;
         prg_regs_ff[1] <= 13'd1;
         outer_ff      <= 8'd0;
         mirror_ff     <= 1'b0;
         reload_val_ff <= 8'hFF;
         count_ff      <= 8'd0;
         irq_en_ff     <= 1'b0;
         pend_ff       <= 1'b0;
         pend_vb_ff    <= 1'b0;
         irq_ff        <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_PRG_COUNT: prg_count_ff <= csr_wdata;
               CSR_CHR_COUNT: chr_count_ff <= csr_wdata[8:0];
               CSR_FOUR_SCR:  four_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (apply) begin
            if (req_command) begin
               if (req_scanline < VIS && req_display_on) begin
                  count_ff   <= cnt_tmp;
                  pend_ff    <= pend_tmp;
                  pend_vb_ff <= 1'b0;
                  if (cnt_tmp == 8'd0 && irq_en_ff) irq_ff <= 1'b1;
               end
            end else if (req_addr == ADDR_OUTER) begin
               outer_ff <= req_data;
            end else if (req_addr[15]) begin
               unique case (dec)
                  DEC_SELECT: bank_select_ff <= req_data;
                  DEC_DATA: begin
                     if (bank_select_ff[2:0] < 3'd2)
                        chr_regs_ff[bank_select_ff[2:0]] <= req_data & 8'hFE;
                     else if (bank_select_ff[2:0] < 3'd6)
                        chr_regs_ff[bank_select_ff[2:0]] <= req_data;
                     else
                        prg_regs_ff[bank_select_ff[0]] <=
                           13'({5'd0, req_data} + {1'b0, outer_ff, 4'd0});
                  end
                  DEC_MIRROR: if (!four_ff) mirror_ff <= req_data[0];
                  DEC_LATCH: reload_val_ff <= req_data;
                  DEC_RELOAD: begin
                     count_ff[7] <= 1'b1;
                     if (req_scanline < VIS) pend_ff <= 1'b1;
                     else begin
                        pend_vb_ff <= 1'b1;
                        pend_ff    <= 1'b0;
                     end
                  end
                  DEC_DISABLE: begin
                     irq_en_ff <= 1'b0;
                     irq_ff    <= 1'b0;
                  end
                  DEC_ENABLE: begin
                     irq_en_ff <= 1'b1;
                     irq_ff    <= 1'b0;
                  end
                  default: ;
               endcase
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (capture) begin
         if (bank_select_ff[6]) begin
            rsp_prg_window_0 <= 13'(n_eff - 14'd2);
            rsp_prg_window_2 <= p_mod_ff[0];
         end else begin
            rsp_prg_window_0 <= p_mod_ff[0];
            rsp_prg_window_2 <= 13'(n_eff - 14'd2);
         end
         rsp_prg_window_1 <= p_mod_ff[1];
         rsp_prg_window_3 <= 13'(n_eff - 14'd1);
         if (bank_select_ff[7])
            rsp_chr_windows <= {c_mod_ff[3], c_mod_ff[2], c_mod_ff[1], c_mod_ff[0],
                                c_mod_ff[7], c_mod_ff[6], c_mod_ff[5], c_mod_ff[4]};
         else
            rsp_chr_windows <= {c_mod_ff[7], c_mod_ff[6], c_mod_ff[5], c_mod_ff[4],
                                c_mod_ff[3], c_mod_ff[2], c_mod_ff[1], c_mod_ff[0]};
         rsp_mirror_mode <= four_ff ? MIRROR_FOUR : {1'b0, mirror_ff};
         rsp_irq_out     <= irq_ff;
      end
   end

   `MMC3_ASSERT_IMPL(a_irq_needs_en, irq_ff, irq_en_ff)
   `MMC3_ASSERT_NEXT(a_disable_clears, apply && !req_command && req_addr[15]
      && dec == DEC_DISABLE, !irq_ff)
   `MMC3_ASSERT_IMPL(a_done_in_range, msts.done && !job[3], msts.result < 14'd256)
endmodule

// ===== hw/rtl/mmc3_ctrl.sv =====
// ---------------------------------------------------------------------------
// mmc3_ctrl
// sequencer: apply request, run ten remainder jobs, present response
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mmc3_bank_and_scanline_irq_defines.svh"
module mmc3_ctrl
   import mmc3_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       mod_done,
   output logic       apply,
   output logic [3:0] job,
   output logic       job_start,
   output logic       capture
);
   typedef enum logic [1:0] {S_IDLE, S_START, S_WAIT, S_OUT} state_type;
   state_type state_ff;
   logic [3:0] job_ff;
   logic       rsp_valid_ff;
   logic       free;

   // jobs 0..7 pattern banks, 8..9 program banks
   assign free      = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign apply     = req_valid && req_ready;
   assign job       = job_ff;
   assign job_start = (state_ff == S_START);
   assign capture   = (state_ff == S_OUT) && free;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         job_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (capture) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (apply) begin
               job_ff   <= 4'd0;
               state_ff <= S_START;
            end
            S_START: state_ff <= S_WAIT;
            S_WAIT: if (mod_done) begin
               if (job_ff == 4'd9) state_ff <= S_OUT;
               else begin
                  job_ff   <= 4'(job_ff + 4'd1);
                  state_ff <= S_START;
               end
            end
            S_OUT: if (free) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `MMC3_ASSERT_IMPL(a_no_accept_busy, state_ff != S_IDLE, !apply)
   `MMC3_ASSERT_NEXT(a_capture_valid, capture, rsp_valid)
   `MMC3_ASSERT_IMPL(a_job_range, state_ff != S_IDLE, job_ff <= 4'd9)
endmodule
